// ===== rtl/core/tbqb_pkg.sv =====
// Shared types and codes of the texture-binned quad batcher.
package tbqb_pkg;

	localparam int CORNERS = 4;
	localparam int TRI_VERTS_PER_QUAD = 6;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_ADD   = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	localparam logic REG_ACTIVE_SLOTS   = 1'b0;
	localparam logic REG_QUADS_PER_SLOT = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] texture_handle;
		logic [3:0]  target_slot;
		logic [63:0] corner_zero;
		logic [63:0] corner_one;
		logic [63:0] corner_two;
		logic [63:0] corner_three;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_hit;
		logic [63:0] tri_vertex_a;
		logic [63:0] tri_vertex_b;
		logic [63:0] tri_vertex_c;
		logic        is_triangle;
		logic        last_of_run;
	} rsp_word_t;

endpackage

// ===== rtl/core/texture_binned_quad_batcher.sv =====
// Top level of the texture-binned quad batcher: slot table, sequencer and vertex store.
//
//   channel   direction  handshake                 word
//   req       in         req_valid / req_ready     tbqb_pkg::req_word_t
//   rsp       out        rsp_valid / rsp_ready     tbqb_pkg::rsp_word_t
//   cfg       in         cfg_we (write only)       cfg_index, cfg_data
//
// Load: IDLE, then REPLY. Add: MATCH, then REPLY on a miss or full slot, or STORE and
// REPLY when the quad is stored (one vertex word per cycle into the vertex store).
// Flush: for each quad FETCH, with four store reads through the registered read port,
// then two triangle words in EMIT0 and EMIT1; an empty slot goes to REPLY.
// Reset clears slot tags and counts at once; the vertex store needs no clearing.
// A stalled rsp holds the sequencer at its next result; req is taken only between items.
module texture_binned_quad_batcher #(
	parameter int TEXTURE_SLOTS = 16,
	parameter int MAX_QUADS     = 32,
	parameter int VERTEX_BITS   = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  tbqb_pkg::req_word_t req_word,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output tbqb_pkg::rsp_word_t rsp_word,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [5:0]          cfg_data
);

	localparam int SW    = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
	localparam int CW    = $clog2(MAX_QUADS + 1);
	localparam int DEPTH = TEXTURE_SLOTS * MAX_QUADS * tbqb_pkg::CORNERS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MATCH = 7'b0000010,
		S_STORE = 7'b0000100,
		S_REPLY = 7'b0001000,
		S_FETCH = 7'b0010000,
		S_EMIT0 = 7'b0100000,
		S_EMIT1 = 7'b1000000
	} state_t;

	state_t                  state_q;
	tbqb_pkg::req_word_t     req_q;
	logic [TEXTURE_SLOTS-1:0] hit_q;
	logic [31:0]             tags_q   [TEXTURE_SLOTS];
	logic [CW-1:0]           counts_q [TEXTURE_SLOTS];
	logic [4:0]              active_q;
	logic [5:0]              capacity_q;
	logic [SW-1:0]           slot_q;
	logic [CW-1:0]           n_q;
	logic [CW-1:0]           quad_q;
	logic [2:0]              cnt_q;
	logic [1:0]              status_q;
	logic [3:0]              reply_slot_q;
	logic [VERTEX_BITS-1:0]  vert_q [tbqb_pkg::CORNERS];
	logic                    rsp_valid_q;
	tbqb_pkg::rsp_word_t     rsp_q;

	logic [TEXTURE_SLOTS-1:0] hit_d;
	logic [SW-1:0]           enc_slot;
	logic                    any_hit;
	logic [SW-1:0]           cnt_rd_idx;
	logic [CW-1:0]           cnt_rd;
	logic                    target_in_range;
	logic                    out_free;
	logic                    rsp_load;
	logic                    ram_we;
	logic [AW-1:0]           ram_addr;
	logic [VERTEX_BITS-1:0]  ram_wdata;
	logic [VERTEX_BITS-1:0]  ram_rdata;
	logic [CW-1:0]           addr_quad;
	logic [1:0]              cap_idx;
	logic                    last_quad;

	assign req_ready       = (state_q == S_IDLE);
	assign rsp_valid       = rsp_valid_q;
	assign rsp_word        = rsp_q;
	assign out_free        = !rsp_valid_q || rsp_ready;
	assign rsp_load        = out_free &&
		(state_q == S_REPLY || state_q == S_EMIT0 || state_q == S_EMIT1);
	assign target_in_range = (int'(req_word.target_slot) < TEXTURE_SLOTS);
	assign cap_idx         = 2'(cnt_q - 3'd1);
	assign last_quad       = (CW'(quad_q + 1'b1) == n_q);

	always_comb begin
		for (int s = 0; s < TEXTURE_SLOTS; s++) begin
			hit_d[s] = (tags_q[s] == req_word.texture_handle) && (s < int'(active_q));
		end
	end

	always_comb begin
		enc_slot = '0;
		for (int s = TEXTURE_SLOTS - 1; s >= 0; s--) begin
			if (hit_q[s]) begin
				enc_slot = SW'(s);
			end
		end
	end

	assign any_hit    = |hit_q;
	assign cnt_rd_idx = (state_q == S_MATCH) ? enc_slot : SW'(req_word.target_slot);
	assign cnt_rd     = counts_q[cnt_rd_idx];

	assign ram_we    = (state_q == S_STORE);
	assign addr_quad = (state_q == S_STORE) ? n_q : quad_q;
	assign ram_addr  = AW'((int'(slot_q) * MAX_QUADS + int'(addr_quad)) * tbqb_pkg::CORNERS
		+ int'(cnt_q[1:0]));

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: ram_wdata = req_q.corner_zero[VERTEX_BITS-1:0];
			2'd1: ram_wdata = req_q.corner_one[VERTEX_BITS-1:0];
			2'd2: ram_wdata = req_q.corner_two[VERTEX_BITS-1:0];
			default: ram_wdata = req_q.corner_three[VERTEX_BITS-1:0];
		endcase
	end

	tbqb_ram #(
		.WIDTH(VERTEX_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 5'd16;
			capacity_q <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbqb_pkg::REG_ACTIVE_SLOTS:   active_q   <= cfg_data[4:0];
				tbqb_pkg::REG_QUADS_PER_SLOT: capacity_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req_word;
			hit_q <= hit_d;
		end
		if (state_q == S_FETCH && cnt_q != 3'd0) begin
			vert_q[cap_idx] <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
			slot_q       <= '0;
			n_q          <= '0;
			quad_q       <= '0;
			cnt_q        <= '0;
			status_q     <= tbqb_pkg::ST_OK;
			reply_slot_q <= '0;
			for (int s = 0; s < TEXTURE_SLOTS; s++) begin
				tags_q[s]   <= '0;
				counts_q[s] <= '0;
			end
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						reply_slot_q <= req_word.target_slot;
						priority case (req_word.req_type)
							tbqb_pkg::REQ_LOAD: begin
								if (target_in_range) begin
									tags_q[SW'(req_word.target_slot)]   <= req_word.texture_handle;
									counts_q[SW'(req_word.target_slot)] <= '0;
									status_q <= tbqb_pkg::ST_OK;
								end else begin
									status_q <= tbqb_pkg::ST_NOT_FOUND;
								end
								state_q <= S_REPLY;
							end
							tbqb_pkg::REQ_ADD: begin
								state_q <= S_MATCH;
							end
							tbqb_pkg::REQ_FLUSH: begin
								if (!target_in_range || cnt_rd == '0) begin
									status_q <= tbqb_pkg::ST_EMPTY;
									state_q  <= S_REPLY;
								end else begin
									slot_q  <= SW'(req_word.target_slot);
									n_q     <= cnt_rd;
									quad_q  <= '0;
									cnt_q   <= '0;
									state_q <= S_FETCH;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_MATCH: begin
					if (!any_hit) begin
						status_q     <= tbqb_pkg::ST_NOT_FOUND;
						reply_slot_q <= '0;
						state_q      <= S_REPLY;
					end else if (7'(cnt_rd) >= 7'(capacity_q) || int'(cnt_rd) >= MAX_QUADS) begin
						status_q     <= tbqb_pkg::ST_FULL;
						reply_slot_q <= 4'(enc_slot);
						state_q      <= S_REPLY;
					end else begin
						status_q     <= tbqb_pkg::ST_OK;
						reply_slot_q <= 4'(enc_slot);
						slot_q       <= enc_slot;
						n_q          <= cnt_rd;
						cnt_q        <= '0;
						state_q      <= S_STORE;
					end
				end
				S_STORE: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						counts_q[slot_q] <= CW'(n_q + 1'b1);
						state_q          <= S_REPLY;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						rsp_q       <= '{status: status_q, slot_hit: reply_slot_q,
							tri_vertex_a: '0, tri_vertex_b: '0, tri_vertex_c: '0,
							is_triangle: 1'b0, last_of_run: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_FETCH: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= S_EMIT0;
					end
				end
				S_EMIT0: begin
					if (out_free) begin
						rsp_q       <= '{status: tbqb_pkg::ST_OK, slot_hit: reply_slot_q,
							tri_vertex_a: 64'(vert_q[0]), tri_vertex_b: 64'(vert_q[1]),
							tri_vertex_c: 64'(vert_q[2]), is_triangle: 1'b1, last_of_run: 1'b0};
						state_q     <= S_EMIT1;
					end
				end
				S_EMIT1: begin
					if (out_free) begin
						rsp_q       <= '{status: tbqb_pkg::ST_OK, slot_hit: reply_slot_q,
							tri_vertex_a: 64'(vert_q[1]), tri_vertex_b: 64'(vert_q[3]),
							tri_vertex_c: 64'(vert_q[2]), is_triangle: 1'b1,
							last_of_run: last_quad};
						if (last_quad) begin
							counts_q[slot_q] <= '0;
							state_q          <= S_IDLE;
						end else begin
							quad_q  <= CW'(quad_q + 1'b1);
							cnt_q   <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_store_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STORE) |-> (int'(n_q) < MAX_QUADS))
		else $error("quad stored beyond slot capacity");

	a_plain_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_word.is_triangle) |->
		(rsp_word.tri_vertex_a == '0 && rsp_word.tri_vertex_b == '0 &&
		rsp_word.tri_vertex_c == '0 && rsp_word.last_of_run))
		else $error("status word carries vertex data or is not last");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)))
		else $error("result word dropped or changed while stalled");
`endif

endmodule

// ===== rtl/core/tbqb_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module tbqb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
